/* src/multichannel_biquad_four_forms_unit_defines.svh */
// Assertion macros for the checker file of the biquad unit.
`ifndef MULTICHANNEL_BIQUAD_FOUR_FORMS_UNIT_DEFINES_SVH
`define MULTICHANNEL_BIQUAD_FOUR_FORMS_UNIT_DEFINES_SVH

// Checked only while out of reset.
`define MBQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define MBQ_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/mbq_pkg.sv */
// Types, constants and the per-form micro-op program of the biquad unit.
`timescale 1ns / 1ps

package mbq_pkg;

  localparam int CHAN_BITS    = 3;
  localparam int CFG_IDX_BITS = 3;
  localparam int COEF_BITS    = 32;
  localparam int CHUNK_BITS   = 32;
  localparam int FRAC_BITS    = 28;
  localparam int STEP_BITS    = 3;

  localparam logic signed [COEF_BITS-1:0] COEF_UNITY = 32'sh1000_0000;

  // slot order of one channel's state row
  localparam int SLOT_X1 = 0;
  localparam int SLOT_X2 = 1;
  localparam int SLOT_Y1 = 2;
  localparam int SLOT_Y2 = 3;
  localparam int SLOT_W1 = 4;
  localparam int SLOT_W2 = 5;
  localparam int SLOTS   = 6;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FORM = 3'd0,
    REG_B0   = 3'd1,
    REG_B1   = 3'd2,
    REG_B2   = 3'd3,
    REG_A1   = 3'd4,
    REG_A2   = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    FORM_DF1  = 2'd0,
    FORM_DF2  = 2'd1,
    FORM_DF1T = 2'd2,
    FORM_DF2T = 2'd3
  } form_t;

  typedef enum logic [3:0] {
    SRC_ZERO, SRC_X, SRC_X1, SRC_X2, SRC_Y1, SRC_Y2, SRC_W1, SRC_W2, SRC_W, SRC_Y
  } src_t;

  typedef enum logic [2:0] {
    COEF_B0, COEF_B1, COEF_B2, COEF_A1, COEF_A2, COEF_ONE
  } coef_t;

  typedef enum logic [2:0] {
    DST_NONE, DST_W, DST_Y, DST_YOUT, DST_X1, DST_X2, DST_W1, DST_W2
  } dst_t;

  // one product term; first preloads the sum with the addend, dst closes the sum
  typedef struct packed {
    logic  first;
    src_t  add_src;
    src_t  mul_src;
    coef_t coef;
    dst_t  dst;
    logic  done;
  } uop_t;

  typedef struct packed {
    logic mul_en;
    logic pacc_en;
    logic pacc_first;
    logic add_en;
    logic add_first;
  } mac_ctrl_t;

  function automatic uop_t mk(input logic first, input src_t a, input src_t m,
                              input coef_t c, input dst_t d, input logic done);
    uop_t u;
    u.first   = first;
    u.add_src = a;
    u.mul_src = m;
    u.coef    = c;
    u.dst     = d;
    u.done    = done;
    return u;
  endfunction

  function automatic uop_t prog(input form_t f, input logic [STEP_BITS-1:0] step);
    uop_t u;
    u = mk(1'b1, SRC_ZERO, SRC_ZERO, COEF_ONE, DST_NONE, 1'b1);
    unique case (f)
      FORM_DF1: begin
        unique case (step)
          3'd0: u = mk(1'b1, SRC_ZERO, SRC_X,  COEF_B0, DST_NONE, 1'b0);
          3'd1: u = mk(1'b0, SRC_ZERO, SRC_X1, COEF_B1, DST_NONE, 1'b0);
          3'd2: u = mk(1'b0, SRC_ZERO, SRC_X2, COEF_B2, DST_NONE, 1'b0);
          3'd3: u = mk(1'b0, SRC_ZERO, SRC_Y1, COEF_A1, DST_NONE, 1'b0);
          3'd4: u = mk(1'b0, SRC_ZERO, SRC_Y2, COEF_A2, DST_Y,    1'b1);
          default: ;
        endcase
      end
      FORM_DF2: begin
        unique case (step)
          3'd0: u = mk(1'b1, SRC_X,    SRC_W1, COEF_A1, DST_NONE, 1'b0);
          3'd1: u = mk(1'b0, SRC_ZERO, SRC_W2, COEF_A2, DST_W,    1'b0);
          3'd2: u = mk(1'b1, SRC_ZERO, SRC_W,  COEF_B0, DST_NONE, 1'b0);
          3'd3: u = mk(1'b0, SRC_ZERO, SRC_W1, COEF_B1, DST_NONE, 1'b0);
          3'd4: u = mk(1'b0, SRC_ZERO, SRC_W2, COEF_B2, DST_YOUT, 1'b1);
          default: ;
        endcase
      end
      FORM_DF1T: begin
        unique case (step)
          3'd0: u = mk(1'b1, SRC_X,    SRC_W2, COEF_ONE, DST_W,    1'b0);
          3'd1: u = mk(1'b1, SRC_X2,   SRC_W,  COEF_B0,  DST_YOUT, 1'b0);
          3'd2: u = mk(1'b1, SRC_X1,   SRC_W,  COEF_B1,  DST_X2,   1'b0);
          3'd3: u = mk(1'b1, SRC_ZERO, SRC_W,  COEF_B2,  DST_X1,   1'b0);
          3'd4: u = mk(1'b1, SRC_W1,   SRC_W,  COEF_A1,  DST_W2,   1'b0);
          3'd5: u = mk(1'b1, SRC_ZERO, SRC_W,  COEF_A2,  DST_W1,   1'b1);
          default: ;
        endcase
      end
      FORM_DF2T: begin
        unique case (step)
          3'd0: u = mk(1'b1, SRC_X2,   SRC_X, COEF_B0, DST_Y,    1'b0);
          3'd1: u = mk(1'b1, SRC_X1,   SRC_X, COEF_B1, DST_NONE, 1'b0);
          3'd2: u = mk(1'b0, SRC_ZERO, SRC_Y, COEF_A1, DST_X2,   1'b0);
          3'd3: u = mk(1'b1, SRC_ZERO, SRC_X, COEF_B2, DST_NONE, 1'b0);
          3'd4: u = mk(1'b0, SRC_ZERO, SRC_Y, COEF_A2, DST_X1,   1'b1);
          default: ;
        endcase
      end
    endcase
    return u;
  endfunction

endpackage

/* src/mbq_ram.sv */
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module mbq_ram #(
  parameter int WIDTH = 240,
  parameter int DEPTH = 8
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic                                      rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* src/mbq_mac.sv */
// Shared chunked multiplier with Q28 truncation and sum accumulator.
`timescale 1ns / 1ps

module mbq_mac #(
  parameter int VW    = 40,
  parameter int NCH   = 2,
  parameter int ACC_W = 48
) (
  input  logic                                  clk,
  input  mbq_pkg::mac_ctrl_t                    ctrl,
  input  logic [((NCH > 1) ? $clog2(NCH) : 1)-1:0] chunk_sel,
  input  logic signed [VW-1:0]                  opnd,
  input  logic signed [mbq_pkg::COEF_BITS-1:0]  coef,
  input  logic signed [VW-1:0]                  addend,
  output logic signed [ACC_W-1:0]               sum
);
  import mbq_pkg::*;

  localparam int KW   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int PADW = NCH * CHUNK_BITS;
  localparam int MW   = CHUNK_BITS + 1 + COEF_BITS;
  localparam int PW   = PADW + CHUNK_BITS + 1;

  logic signed [PADW-1:0]       opnd_pad;
  logic [CHUNK_BITS-1:0]        chunk;
  logic                         top;
  logic signed [CHUNK_BITS:0]   mul_a;
  logic signed [MW-1:0]         mul_r;
  logic signed [PW-1:0]         prod_r;
  logic signed [ACC_W-1:0]      term;
  logic signed [ACC_W-1:0]      base;
  logic signed [ACC_W-1:0]      acc_r;

  assign opnd_pad = PADW'(opnd);
  assign chunk    = opnd_pad[chunk_sel*CHUNK_BITS +: CHUNK_BITS];
  assign top      = (chunk_sel == KW'(NCH - 1));
  // lower chunks are unsigned, the top chunk carries the sign
  assign mul_a    = $signed({top & chunk[CHUNK_BITS-1], chunk});

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      mul_r <= mul_a * coef;
    end
    if (ctrl.pacc_en) begin
      prod_r <= ctrl.pacc_first ? PW'(mul_r) : (prod_r <<< CHUNK_BITS) + PW'(mul_r);
    end
    if (ctrl.add_en) begin
      acc_r <= sum;
    end
  end

  assign term = ACC_W'(prod_r >>> FRAC_BITS);
  assign base = ctrl.add_first ? ACC_W'(addend) : acc_r;
  assign sum  = base + term;

endmodule

/* src/multichannel_biquad_four_forms_unit.sv */
// Multichannel biquad section with four selectable forms, top level.
//
//   channel | signals                                   | beat
//   in      | in_valid/in_ready, in_chan_index, in_sample_in | one sample of one channel
//   out     | out_valid/out_ready, out_sample_out       | one filtered sample
//   cfg     | cfg_we, cfg_index, cfg_wdata              | one register write
//
// Each beat runs U product terms through the one shared multiplier, each term in NCH chunks,
// NCH = ceil(max(STATE_BITS,SAMPLE_BITS)/32), U = 5 (6 in direct form I transposed); no new
// sample is taken until the beat is written back. A channel out of range goes straight to
// write-back. Reset and form writes clear per-channel valid bits at once; no clearing pass.
// A result waiting in the output register does not block the next beat; only the write-back
// of the following one waits for it.
`timescale 1ns / 1ps

module multichannel_biquad_four_forms_unit #(
  parameter int CHANNELS    = 8,
  parameter int SAMPLE_BITS = 24,
  parameter int STATE_BITS  = 40
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [mbq_pkg::CHAN_BITS-1:0]           in_chan_index,
  input  logic signed [SAMPLE_BITS-1:0]           in_sample_in,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [SAMPLE_BITS-1:0]           out_sample_out,
  input  logic                                    cfg_we,
  input  logic [mbq_pkg::CFG_IDX_BITS-1:0]        cfg_index,
  input  logic [mbq_pkg::COEF_BITS-1:0]           cfg_wdata
);
  import mbq_pkg::*;

  localparam int VW    = (STATE_BITS > SAMPLE_BITS) ? STATE_BITS : SAMPLE_BITS;
  localparam int NCH   = (VW + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int KW    = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int ACC_W = VW + 8;
  localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int XW    = (AW > CHAN_BITS) ? AW : CHAN_BITS;
  localparam int ROW_W = SLOTS * VW;

  localparam logic signed [ACC_W-1:0] ST_MAX =
    {{(ACC_W-STATE_BITS+1){1'b0}}, {(STATE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ST_MIN = ~ST_MAX;
  localparam logic signed [ACC_W-1:0] SM_MAX =
    {{(ACC_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SM_MIN = ~SM_MAX;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_READ = 6'b000010,
    S_MUL  = 6'b000100,
    S_PACC = 6'b001000,
    S_ADD  = 6'b010000,
    S_WB   = 6'b100000
  } state_t;

  function automatic logic signed [VW-1:0] sat_st(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    if (a > ST_MAX) r = ST_MAX;
    else if (a < ST_MIN) r = ST_MIN;
    else r = a;
    return VW'(r);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sm(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] r;
    if (a > SM_MAX) r = SM_MAX;
    else if (a < SM_MIN) r = SM_MIN;
    else r = a;
    return SAMPLE_BITS'(r);
  endfunction

  state_t                        state_r, state_nxt;
  form_t                         form_r;
  logic signed [COEF_BITS-1:0]   b0_r, b1_r, b2_r, a1_r, a2_r;
  logic                          vld_r [CHANNELS];
  logic signed [VW-1:0]          x_r, x1_r, x2_r, y1_r, y2_r, w1_r, w2_r, w_r, y_r;
  logic [AW-1:0]                 idx_r;
  logic                          bad_r;
  logic                          row_vld_r;
  logic [STEP_BITS-1:0]          step_r;
  logic [KW-1:0]                 k_r;
  logic signed [SAMPLE_BITS-1:0] res_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_data_r;

  logic [XW-1:0]                 chan_x;
  logic                          chan_ok;
  logic [AW-1:0]                 in_idx;
  logic                          accept;
  logic                          wb_go;
  uop_t                          uop;
  logic signed [VW-1:0]          add_val, mul_val;
  logic signed [COEF_BITS-1:0]   coef_val;
  mac_ctrl_t                     mac_ctrl;
  logic signed [ACC_W-1:0]       mac_sum;
  logic signed [VW-1:0]          sum_st;
  logic [ROW_W-1:0]              rd_row, wr_row;
  logic signed [VW-1:0]          nx1, nx2, ny1, ny2, nw1, nw2;

  assign in_ready       = (state_r == S_IDLE);
  assign accept         = in_valid && in_ready;
  assign chan_x         = XW'(in_chan_index);
  assign chan_ok        = ({1'b0, chan_x} < (XW+1)'(CHANNELS));
  assign in_idx         = chan_x[AW-1:0];
  assign wb_go          = (state_r == S_WB) && (!out_valid_r || out_ready);
  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;
  assign uop            = prog(form_r, step_r);
  assign sum_st         = sat_st(mac_sum);

  always_comb begin
    unique case (uop.add_src)
      SRC_X:   add_val = x_r;
      SRC_X1:  add_val = x1_r;
      SRC_X2:  add_val = x2_r;
      SRC_Y1:  add_val = y1_r;
      SRC_Y2:  add_val = y2_r;
      SRC_W1:  add_val = w1_r;
      SRC_W2:  add_val = w2_r;
      SRC_W:   add_val = w_r;
      SRC_Y:   add_val = y_r;
      default: add_val = '0;
    endcase
    unique case (uop.mul_src)
      SRC_X:   mul_val = x_r;
      SRC_X1:  mul_val = x1_r;
      SRC_X2:  mul_val = x2_r;
      SRC_Y1:  mul_val = y1_r;
      SRC_Y2:  mul_val = y2_r;
      SRC_W1:  mul_val = w1_r;
      SRC_W2:  mul_val = w2_r;
      SRC_W:   mul_val = w_r;
      SRC_Y:   mul_val = y_r;
      default: mul_val = '0;
    endcase
    unique case (uop.coef)
      COEF_B0: coef_val = b0_r;
      COEF_B1: coef_val = b1_r;
      COEF_B2: coef_val = b2_r;
      COEF_A1: coef_val = a1_r;
      COEF_A2: coef_val = a2_r;
      default: coef_val = COEF_UNITY;
    endcase
  end

  always_comb begin
    mac_ctrl.mul_en     = (state_r == S_MUL);
    mac_ctrl.pacc_en    = (state_r == S_PACC);
    mac_ctrl.pacc_first = (k_r == KW'(NCH - 1));
    mac_ctrl.add_en     = (state_r == S_ADD);
    mac_ctrl.add_first  = uop.first;
  end

  mbq_mac #(
    .VW    (VW),
    .NCH   (NCH),
    .ACC_W (ACC_W)
  ) u_mac (
    .clk       (clk),
    .ctrl      (mac_ctrl),
    .chunk_sel (k_r),
    .opnd      (mul_val),
    .coef      (coef_val),
    .addend    (add_val),
    .sum       (mac_sum)
  );

  always_comb begin
    nx1 = x1_r;
    nx2 = x2_r;
    ny1 = y1_r;
    ny2 = y2_r;
    nw1 = w1_r;
    nw2 = w2_r;
    unique case (form_r)
      FORM_DF1: begin
        nx2 = x1_r;
        nx1 = x_r;
        ny2 = y1_r;
        ny1 = y_r;
      end
      FORM_DF2: begin
        nw2 = w1_r;
        nw1 = w_r;
      end
      FORM_DF1T, FORM_DF2T: ;
    endcase
    wr_row = {nw2, nw1, ny2, ny1, nx2, nx1};
  end

  mbq_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk     (clk),
    .wr_en   (wb_go && !bad_r),
    .wr_addr (idx_r),
    .wr_data (wr_row),
    .rd_en   (accept && chan_ok),
    .rd_addr (in_idx),
    .rd_data (rd_row)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = chan_ok ? S_READ : S_WB;
      S_READ: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_PACC;
      S_PACC: if (k_r == '0) state_nxt = S_ADD;
              else state_nxt = S_MUL;
      S_ADD:  state_nxt = uop.done ? S_WB : S_MUL;
      S_WB:   if (wb_go) state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      form_r      <= FORM_DF2T;
      b0_r        <= COEF_UNITY;
      b1_r        <= '0;
      b2_r        <= '0;
      a1_r        <= '0;
      a2_r        <= '0;
      for (int i = 0; i < CHANNELS; i++) vld_r[i] <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (wb_go) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_FORM: begin
            form_r <= form_t'(cfg_wdata[1:0]);
            for (int i = 0; i < CHANNELS; i++) vld_r[i] <= 1'b0;
          end
          REG_B0:  b0_r <= cfg_wdata;
          REG_B1:  b1_r <= cfg_wdata;
          REG_B2:  b2_r <= cfg_wdata;
          REG_A1:  a1_r <= cfg_wdata;
          REG_A2:  a2_r <= cfg_wdata;
          default: ;
        endcase
      end else if (wb_go && !bad_r) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (idx_r == AW'(i)) vld_r[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x_r       <= VW'(in_sample_in);
      idx_r     <= in_idx;
      bad_r     <= !chan_ok;
      row_vld_r <= chan_ok && vld_r[in_idx];
      step_r    <= '0;
      k_r       <= KW'(NCH - 1);
      res_r     <= '0;
    end
    if (state_r == S_READ) begin
      x1_r <= row_vld_r ? rd_row[SLOT_X1*VW +: VW] : '0;
      x2_r <= row_vld_r ? rd_row[SLOT_X2*VW +: VW] : '0;
      y1_r <= row_vld_r ? rd_row[SLOT_Y1*VW +: VW] : '0;
      y2_r <= row_vld_r ? rd_row[SLOT_Y2*VW +: VW] : '0;
      w1_r <= row_vld_r ? rd_row[SLOT_W1*VW +: VW] : '0;
      w2_r <= row_vld_r ? rd_row[SLOT_W2*VW +: VW] : '0;
    end
    if (state_r == S_PACC && k_r != '0) begin
      k_r <= k_r - 1'b1;
    end
    if (state_r == S_ADD) begin
      k_r    <= KW'(NCH - 1);
      step_r <= step_r + 1'b1;
      unique case (uop.dst)
        DST_W:   w_r  <= sum_st;
        DST_Y: begin
          y_r   <= sum_st;
          res_r <= sat_sm(ACC_W'(sum_st));
        end
        DST_YOUT: res_r <= sat_sm(mac_sum);
        DST_X1:  x1_r <= sum_st;
        DST_X2:  x2_r <= sum_st;
        DST_W1:  w1_r <= sum_st;
        DST_W2:  w2_r <= sum_st;
        DST_NONE: ;
      endcase
    end
    if (wb_go) begin
      out_data_r <= res_r;
    end
  end

endmodule

/* src/mbq_checker.sv */
// Port-level checker for the biquad unit, with its bind.
`timescale 1ns / 1ps
`include "multichannel_biquad_four_forms_unit_defines.svh"

module mbq_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [SAMPLE_BITS-1:0] out_sample_out
);

  `MBQ_ASSERT_RST(a_reset_idle, !rst_n |=> (in_ready && !out_valid), "not idle after reset")
  `MBQ_ASSERT(a_busy_after_accept, (in_valid && in_ready) |=> !in_ready, "ready after accept")
  `MBQ_ASSERT(a_out_from_work, $rose(out_valid) |-> !$past(in_ready), "result without work")
  `MBQ_ASSERT(a_out_hold, (out_valid && !out_ready) |=> (out_valid && $stable(out_sample_out)), "stalled beat changed")

endmodule

bind multichannel_biquad_four_forms_unit mbq_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_mbq_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_sample_out (out_sample_out)
);

/* tb/sv/tb.sv */
// Self-checking testbench for the multichannel biquad unit: scoreboard class and drivers.
`timescale 1ns / 1ps

module tb;

  localparam int SAMPLE_W    = 24;
  localparam int STATE_W     = 40;
  localparam int NUM_CHAN    = 8;
  localparam int PHASES      = 20;
  localparam int STALL_LIMIT = 2000;
  localparam int ERR_PRINTS  = 100;

  typedef logic signed [95:0]         wide_t;
  typedef logic signed [STATE_W-1:0]  state_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [31:0]         coef_word_t;

  localparam sample_t    SAMPLE_MAX = 24'sh7F_FFFF;
  localparam sample_t    SAMPLE_MIN = 24'sh80_0000;
  localparam coef_word_t COEF_MAX   = 32'sh7FFF_FFFF;
  localparam coef_word_t COEF_MIN   = 32'sh8000_0000;
  localparam coef_word_t Q_QUARTER  = 32'sh0400_0000;
  localparam coef_word_t Q_HALF     = 32'sh0800_0000;

  class biquad_scoreboard;
    mbq_pkg::form_t form;
    coef_word_t ff0, ff1, ff2, fb1, fb2;
    state_t dx1[NUM_CHAN], dx2[NUM_CHAN], dy1[NUM_CHAN], dy2[NUM_CHAN];
    state_t dw1[NUM_CHAN], dw2[NUM_CHAN];
    sample_t due_samples[$];
    int mismatches;

    function new();
      form = mbq_pkg::FORM_DF2T;
      ff0 = mbq_pkg::COEF_UNITY;
      ff1 = '0;
      ff2 = '0;
      fb1 = '0;
      fb2 = '0;
      mismatches = 0;
      clear_delays();
    endfunction

    function void clear_delays();
      for (int i = 0; i < NUM_CHAN; i++) begin
        dx1[i] = '0;
        dx2[i] = '0;
        dy1[i] = '0;
        dy2[i] = '0;
        dw1[i] = '0;
        dw2[i] = '0;
      end
    endfunction

    function void write_reg(input mbq_pkg::cfg_reg_t idx, input logic [31:0] val);
      case (idx)
        mbq_pkg::REG_FORM: begin
          form = mbq_pkg::form_t'(val[1:0]);
          clear_delays();
        end
        mbq_pkg::REG_B0: ff0 = val;
        mbq_pkg::REG_B1: ff1 = val;
        mbq_pkg::REG_B2: ff2 = val;
        mbq_pkg::REG_A1: fb1 = val;
        mbq_pkg::REG_A2: fb2 = val;
        default: ;
      endcase
    endfunction

    // value times Q4.28 coefficient, floored to integer units
    function wide_t mul(input state_t v, input coef_word_t c);
      wide_t pv, pc;
      pv = v;
      pc = c;
      return (pv * pc) >>> mbq_pkg::FRAC_BITS;
    endfunction

    function wide_t clip(input wide_t v, input int n);
      wide_t top, bot;
      top = (wide_t'(1) <<< (n - 1)) - wide_t'(1);
      bot = ~top;
      if (v > top) return top;
      if (v < bot) return bot;
      return v;
    endfunction

    function void run_filter(input logic [2:0] ch, input sample_t x);
      wide_t acc, y;
      state_t w, ys, xs;
      xs = x;
      case (form)
        mbq_pkg::FORM_DF1: begin
          acc = mul(xs, ff0) + mul(dx1[ch], ff1) + mul(dx2[ch], ff2)
              + mul(dy1[ch], fb1) + mul(dy2[ch], fb2);
          ys = state_t'(clip(acc, STATE_W));
          dx2[ch] = dx1[ch];
          dx1[ch] = xs;
          dy2[ch] = dy1[ch];
          dy1[ch] = ys;
          y = wide_t'(ys);
        end
        mbq_pkg::FORM_DF2: begin
          acc = wide_t'(xs) + mul(dw1[ch], fb1) + mul(dw2[ch], fb2);
          w = state_t'(clip(acc, STATE_W));
          y = mul(w, ff0) + mul(dw1[ch], ff1) + mul(dw2[ch], ff2);
          dw2[ch] = dw1[ch];
          dw1[ch] = w;
        end
        mbq_pkg::FORM_DF1T: begin
          w = state_t'(clip(wide_t'(xs) + wide_t'(dw2[ch]), STATE_W));
          y = mul(w, ff0) + wide_t'(dx2[ch]);
          dx2[ch] = state_t'(clip(mul(w, ff1) + wide_t'(dx1[ch]), STATE_W));
          dw2[ch] = state_t'(clip(mul(w, fb1) + wide_t'(dw1[ch]), STATE_W));
          dx1[ch] = state_t'(clip(mul(w, ff2), STATE_W));
          dw1[ch] = state_t'(clip(mul(w, fb2), STATE_W));
        end
        default: begin
          ys = state_t'(clip(mul(xs, ff0) + wide_t'(dx2[ch]), STATE_W));
          acc = mul(xs, ff1) + wide_t'(dx1[ch]) + mul(ys, fb1);
          dx2[ch] = state_t'(clip(acc, STATE_W));
          dx1[ch] = state_t'(clip(mul(xs, ff2) + mul(ys, fb2), STATE_W));
          y = wide_t'(ys);
        end
      endcase
      due_samples.push_back(sample_t'(clip(y, SAMPLE_W)));
    endfunction

    function int outstanding();
      return due_samples.size();
    endfunction

    task report(input string msg);
      if (mismatches < ERR_PRINTS) $display("MISMATCH %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_filtered(input sample_t got);
      sample_t want;
      if (due_samples.size() == 0) begin
        report($sformatf("beat with nothing due, sample_out=%0d", got));
        return;
      end
      want = due_samples.pop_front();
      if (got !== want) report($sformatf("sample_out got %0d want %0d", got, want));
    endtask

    task close_out();
      foreach (due_samples[i]) report($sformatf("sample %0d never arrived", due_samples[i]));
      due_samples.delete();
    endtask
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [2:0]           in_chan_index = '0;
  sample_t              in_sample_in = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  sample_t              out_sample_out;
  logic                 cfg_we = 1'b0;
  mbq_pkg::cfg_reg_t    cfg_index = mbq_pkg::REG_FORM;
  logic [31:0]          cfg_wdata = '0;
  bit                   calm = 1'b0;
  biquad_scoreboard     sb;

  multichannel_biquad_four_forms_unit #(
    .CHANNELS    (NUM_CHAN),
    .SAMPLE_BITS (SAMPLE_W),
    .STATE_BITS  (STATE_W)
  ) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_chan_index  (in_chan_index),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // 0-2 moderate, 3 any word, 4 tame preset, 5 per-coefficient mix incl. rails
  function automatic coef_word_t pick_coef(input int mix, input coef_word_t tame);
    int k;
    k = (mix == 5) ? $urandom_range(0, 3) : ((mix <= 2) ? 0 : ((mix == 3) ? 1 : 4));
    case (k)
      0: return coef_word_t'($urandom_range(0, 32'h2000_0000)) - mbq_pkg::COEF_UNITY;
      1: return coef_word_t'($urandom);
      2: return COEF_MAX;
      3: return COEF_MIN;
      default: return tame;
    endcase
  endfunction

  task automatic send(input logic [2:0] ch, input sample_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_chan_index <= ch;
    in_sample_in  <= s;
    do @(posedge clk); while (!in_ready);
    sb.run_filter(ch, s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input mbq_pkg::cfg_reg_t idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic program_filter(input mbq_pkg::form_t f, input coef_word_t c0,
                                input coef_word_t c1, input coef_word_t c2,
                                input coef_word_t c3, input coef_word_t c4);
    cfg_write(mbq_pkg::REG_B0, c0);
    cfg_write(mbq_pkg::REG_B1, c1);
    cfg_write(mbq_pkg::REG_B2, c2);
    cfg_write(mbq_pkg::REG_A1, c3);
    cfg_write(mbq_pkg::REG_A2, c4);
    cfg_write(mbq_pkg::REG_FORM, {30'b0, f});
    cfg_we <= 1'b0;
  endtask

  // result side: check, then pick ready for the next edge
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) sb.check_filtered(out_sample_out);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else begin
        out_ready <= 1'b1;
        hold = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
      end
    end
  end

  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int n, chan_hi, mix;
    mbq_pkg::form_t f;
    sample_t s;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: transposed direct II, unity pass-through
    calm = 1'b1;
    send(3'd0, SAMPLE_MAX);
    send(3'd1, SAMPLE_MIN);
    send(3'd2, sample_t'(0));
    send(3'd6, sample_t'(-1));
    send(3'd7, sample_t'(1));
    drain();
    program_filter(mbq_pkg::FORM_DF1, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send(3'd0, SAMPLE_MAX);
    send(3'd0, SAMPLE_MIN);
    send(3'd4, SAMPLE_MAX);
    drain();
    program_filter(mbq_pkg::FORM_DF2, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send(3'd3, SAMPLE_MIN);
    send(3'd3, SAMPLE_MAX);
    send(3'd3, SAMPLE_MIN);
    drain();
    program_filter(mbq_pkg::FORM_DF1T, Q_QUARTER, Q_HALF, Q_QUARTER, Q_HALF, -Q_QUARTER);
    send(3'd5, SAMPLE_MAX);
    send(3'd5, sample_t'(0));
    send(3'd5, sample_t'(0));
    send(3'd5, sample_t'(0));
    drain();
    program_filter(mbq_pkg::FORM_DF2T, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
    send(3'd2, SAMPLE_MAX);
    send(3'd2, SAMPLE_MIN);
    send(3'd2, SAMPLE_MAX);
    drain();
    program_filter(mbq_pkg::FORM_DF1, Q_QUARTER, Q_HALF, Q_QUARTER, Q_HALF, -Q_QUARTER);
    send(3'd1, SAMPLE_MIN);
    send(3'd1, sample_t'(0));
    send(3'd1, sample_t'(0));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      f = (p < 8) ? mbq_pkg::form_t'(p % 4) : mbq_pkg::form_t'($urandom_range(0, 3));
      mix = $urandom_range(0, 5);
      program_filter(f, pick_coef(mix, Q_QUARTER), pick_coef(mix, Q_HALF),
                     pick_coef(mix, Q_QUARTER), pick_coef(mix, Q_HALF),
                     pick_coef(mix, -Q_QUARTER));
      calm = (p % 4 == 1);
      chan_hi = (p % 3 == 0) ? NUM_CHAN - 1 : $urandom_range(0, NUM_CHAN - 1);
      n = $urandom_range(30, 54);
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(0, 9))
          6, 7: s = sample_t'($urandom_range(0, 2000)) - sample_t'(1000);
          8: s = SAMPLE_MAX;
          9: s = SAMPLE_MIN;
          default: s = sample_t'($urandom);
        endcase
        send(3'($urandom_range(0, chan_hi)), s);
      end
    end

    drain();
    repeat (40) @(posedge clk);
    sb.close_out();
    if (sb.mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
